>>> sv/asps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asps_pkg: shared types and constants for the path search block
// Function codes, node count, score limits and the sequencer state encoding.
// ----------------------------------------------------------------------------
package asps_pkg;

  // number of graph nodes
  localparam int MAX_NODES = 16;

  // function codes of an input word
  localparam logic [1:0] FUNC_EDGE   = 2'd0;
  localparam logic [1:0] FUNC_HEUR   = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [15:0] SCORE_INF = 16'hFFFF;
  localparam logic [15:0] COST_MAX  = 16'hFFFE;
  localparam int unsigned RESULT_MAX = 16;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_CLEAR = 10'b0000000010,
    ST_SCAN  = 10'b0000000100,
    ST_PICK  = 10'b0000001000,
    ST_RELAX = 10'b0000010000,
    ST_RWAIT = 10'b0000100000,
    ST_COST  = 10'b0001000000,
    ST_CWAIT = 10'b0010000000,
    ST_EMIT  = 10'b0100000000,
    ST_NONE  = 10'b1000000000
  } state_t;

endpackage
`default_nettype wire

>>> sv/astar_path_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// astar_path_search_top: A* shortest path search over a loaded graph
// Edge and heuristic words load local stores; a search word runs A* and
// streams the path from goal back to start.
// ----------------------------------------------------------------------------
// A heuristic load writes the heuristic store. An edge load is a single write,
// or two when it carries a nonzero weight between two different nodes, since
// the weight is written to both directions of a MAX_NODES^2 weight memory in
// two writes (the adjacency bit sits in its own memory, set by the first).
// A search holds in_ready low while the sequencer walks the nodes: it clears the
// node state, then per expansion runs a minimum scan, one pick step and neighbor
// relaxation through the memory read port (a read state and a wait state per
// neighbor), then a cost state and a wait state per path hop for the cost sum
// and one emit step per path word, which output stalls can hold; in_ready stays
// low until the last word of a search is taken. After reset the weight and
// adjacency memories are swept clear before the first word is accepted.
module astar_path_search_top (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [1:0]  func,
  input  wire [3:0]  first_node,
  input  wire [3:0]  second_node,
  input  wire [7:0]  edge_weight,
  input  wire [7:0]  heuristic_value,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       found,
  output logic [3:0] path_node,
  output logic [15:0] path_cost,
  output logic       last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [7:0]  cfg_data
);

  localparam int MAX_NODES = asps_pkg::MAX_NODES;
  localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int AW = 2 * NW;
  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam logic [NW:0] NLIM = (NW + 1)'(MAX_NODES);

  // configuration register
  logic [7:0] default_weight;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) default_weight <= 8'd1;
    else if (cfg_valid) default_weight <= cfg_data;
  end

  // graph memories: adjacency bits and 8-bit weights (0 = unassigned)
  logic          adj_mem [DEPTH];
  logic [7:0]    wgt_mem [DEPTH];
  logic          adj_rd;
  logic [7:0]    wgt_rd;
  logic          awe, awd, wwe;
  logic [AW-1:0] awa, wwa, gra;
  logic [7:0]    wwd;
  always_ff @(posedge clk) begin
    if (awe) adj_mem[awa] <= awd;
    if (wwe) wgt_mem[wwa] <= wwd;
    adj_rd <= adj_mem[gra];
    wgt_rd <= wgt_mem[gra];
  end

  // node stores
  logic [7:0]  heur  [MAX_NODES];
  logic [15:0] score [MAX_NODES];
  logic [NW-1:0] came [MAX_NODES];
  logic [MAX_NODES-1:0] has_par, closed;

  asps_pkg::state_t state;
  logic [AW:0]   sweep;        // reset clearing pass counter
  logic          sweeping;
  logic          pend;         // second half of an edge write
  logic [AW-1:0] pend_a;
  logic [7:0]    pend_w;
  logic [NW:0]   idx;          // shared scan counter
  logic [NW-1:0] start, goal, act, best_n, cur;
  logic [15:0]   best_s, gval, cost;
  logic          best_ok;
  logic [NW:0]   iter, hops, k;
  logic [NW-1:0] rel_c;

  // heuristic of node n toward goal
  function automatic logic [15:0] est(input logic [NW-1:0] n, input logic [NW-1:0] g,
                                      input logic [7:0] h);
    logic [15:0] r;
    r = 16'd0;
    if (n != g) begin
      if (h != 8'd0) r = {8'd0, h};
      else if (n > g) r = 16'(n - g);
      else r = 16'(g - n);
    end
    return r;
  endfunction

  logic [NW-1:0] idn;
  assign idn = idx[NW-1:0];

  // relaxation datapath: one add and compare per neighbor
  logic [7:0]  wsel;
  logic [17:0] tsum;
  logic [15:0] tsat;
  always_comb begin
    wsel = (wgt_rd != 8'd0) ? wgt_rd : default_weight;
    if (rel_c == act) wsel = 8'd0;
    tsum = 18'(gval) + 18'(wsel) + 18'(est(rel_c, goal, heur[rel_c]));
    tsat = (tsum > 18'(asps_pkg::COST_MAX)) ? asps_pkg::COST_MAX : tsum[15:0];
  end

  // cost accumulation over one hop
  logic [7:0]  cw;
  logic [16:0] csum;
  always_comb begin
    cw = (wgt_rd != 8'd0) ? wgt_rd : default_weight;
    if (cur == came[cur]) cw = 8'd0;
    csum = 17'(cost) + 17'(cw);
  end

  logic in_fire, out_fire;
  assign in_ready = (state == asps_pkg::ST_IDLE) && !sweeping && !pend && !out_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // memory address and write select
  always_comb begin
    awe = 1'b0;
    awa = '0;
    awd = 1'b0;
    wwe = 1'b0;
    wwa = '0;
    wwd = '0;
    gra = '0;
    if (sweeping) begin
      awe = 1'b1;
      awa = sweep[AW-1:0];
      wwe = 1'b1;
      wwa = sweep[AW-1:0];
    end else if (pend) begin
      // mirrored weight
      wwe = 1'b1;
      wwa = pend_a;
      wwd = pend_w;
    end else if (in_fire && func == asps_pkg::FUNC_EDGE &&
                 {1'b0, first_node} < 5'(MAX_NODES) &&
                 {1'b0, second_node} < 5'(MAX_NODES)) begin
      awe = 1'b1;
      awa = {first_node[NW-1:0], second_node[NW-1:0]};
      awd = 1'b1;
      wwe = (edge_weight != 8'd0);
      wwa = {first_node[NW-1:0], second_node[NW-1:0]};
      wwd = edge_weight;
    end
    if (state == asps_pkg::ST_RELAX) gra = {act, idn};
    else if (state == asps_pkg::ST_COST) gra = {cur, came[cur]};
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= asps_pkg::ST_IDLE;
      sweeping <= 1'b1;
      sweep    <= '0;
      pend     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_NODES; i++) heur[i] <= 8'd0;
    end else begin
      if (sweeping) begin
        sweep <= sweep + 1'b1;
        if (sweep == (AW + 1)'(DEPTH - 1)) sweeping <= 1'b0;
      end
      if (pend) pend <= 1'b0;
      unique case (state)
        asps_pkg::ST_IDLE: begin
          // only the closing word of a search waits here
          if (out_fire) out_valid <= 1'b0;
          if (in_fire) begin
            if (func == asps_pkg::FUNC_EDGE) begin
              if ({1'b0, first_node} < 5'(MAX_NODES) && {1'b0, second_node} < 5'(MAX_NODES) &&
                  edge_weight != 8'd0 && first_node != second_node) begin
                pend   <= 1'b1;
                pend_a <= {second_node[NW-1:0], first_node[NW-1:0]};
                pend_w <= edge_weight;
              end
            end else if (func == asps_pkg::FUNC_HEUR) begin
              if ({1'b0, first_node} < 5'(MAX_NODES)) heur[first_node[NW-1:0]] <= heuristic_value;
            end else if (func == asps_pkg::FUNC_SEARCH) begin
              if ({1'b0, first_node} < 5'(MAX_NODES) && {1'b0, second_node} < 5'(MAX_NODES)) begin
                start <= first_node[NW-1:0];
                goal  <= second_node[NW-1:0];
                idx   <= '0;
                state <= asps_pkg::ST_CLEAR;
              end else begin
                state <= asps_pkg::ST_NONE;
              end
            end
          end
        end
        asps_pkg::ST_CLEAR: begin
          score[idn]   <= (idn == start) ? est(start, goal, heur[start]) : asps_pkg::SCORE_INF;
          came[idn]    <= '0;
          has_par[idn] <= 1'b0;
          closed[idn]  <= 1'b0;
          if (idx == NLIM - 1'b1) begin
            iter <= '0;
            idx <= '0;
            best_ok <= 1'b0;
            best_s <= asps_pkg::SCORE_INF;
            state <= asps_pkg::ST_SCAN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        asps_pkg::ST_SCAN: begin
          // serial minimum search, strict compare keeps lowest index
          if (!closed[idn] && score[idn] < best_s) begin
            best_s <= score[idn];
            best_n <= idn;
            best_ok <= 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == NLIM - 1'b1) state <= asps_pkg::ST_PICK;
        end
        asps_pkg::ST_PICK: begin
          if (!best_ok) begin
            state <= asps_pkg::ST_NONE;
          end else begin
            closed[best_n] <= 1'b1;
            act <= best_n;
            if (best_n == goal) begin
              cur <= goal;
              cost <= '0;
              hops <= '0;
              state <= asps_pkg::ST_COST;
            end else begin
              gval <= (best_s >= est(best_n, goal, heur[best_n])) ?
                      best_s - est(best_n, goal, heur[best_n]) : 16'd0;
              idx <= '0;
              state <= asps_pkg::ST_RELAX;
            end
          end
        end
        asps_pkg::ST_RELAX: begin
          rel_c <= idn;
          state <= asps_pkg::ST_RWAIT;
        end
        asps_pkg::ST_RWAIT: begin
          if (adj_rd && tsat < score[rel_c]) begin
            score[rel_c]   <= tsat;
            came[rel_c]    <= act;
            has_par[rel_c] <= 1'b1;
          end
          if (idx == NLIM - 1'b1) begin
            iter <= iter + 1'b1;
            idx <= '0;
            best_ok <= 1'b0;
            best_s <= asps_pkg::SCORE_INF;
            state <= (iter == NLIM - 1'b1) ? asps_pkg::ST_NONE : asps_pkg::ST_SCAN;
          end else begin
            idx <= idx + 1'b1;
            state <= asps_pkg::ST_RELAX;
          end
        end
        asps_pkg::ST_COST: begin
          if (hops == NLIM || !has_par[cur]) begin
            cur <= goal;
            k <= '0;
            state <= asps_pkg::ST_EMIT;
          end else begin
            state <= asps_pkg::ST_CWAIT;
          end
        end
        asps_pkg::ST_CWAIT: begin
          cost <= (csum > 17'(asps_pkg::COST_MAX)) ? asps_pkg::COST_MAX : csum[15:0];
          cur <= came[cur];
          hops <= hops + 1'b1;
          state <= asps_pkg::ST_COST;
        end
        asps_pkg::ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            found <= 1'b1;
            path_node <= 4'(cur);
            path_cost <= cost;
            last <= !has_par[cur] || (5'(k) == 5'(asps_pkg::RESULT_MAX - 1));
            cur <= came[cur];
            k <= k + 1'b1;
            if (!has_par[cur] || (5'(k) == 5'(asps_pkg::RESULT_MAX - 1)))
              state <= asps_pkg::ST_IDLE;
          end
        end
        asps_pkg::ST_NONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            found <= 1'b0;
            path_node <= '0;
            path_cost <= '0;
            last <= 1'b1;
            state <= asps_pkg::ST_IDLE;
          end
        end
        default: state <= asps_pkg::ST_IDLE;
      endcase
    end
  end

  // no input is taken while a search is running or its words are pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != asps_pkg::ST_IDLE) |-> !in_ready)
    else $error("input accepted during search");
  // the last word of a search returns the sequencer to idle
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last) |-> (state == asps_pkg::ST_IDLE))
    else $error("last word while still searching");
  // a not-found word carries zero payload
  a_nf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (last && path_cost == 16'd0 && path_node == 4'd0))
    else $error("bad not-found word");

endmodule
`default_nettype wire

>>> dv/astar_path_search_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// astar_path_search_top_tb: self-checking bench for the A* path search block
// Loads directed and random graphs and heuristics, runs searches, and compares every
// streamed path word against a behavioral predictor held in a scoreboard.
// ----------------------------------------------------------------------------

// predicted path word
typedef struct packed {
  logic        found;
  logic [3:0]  node;
  logic [15:0] cost;
  logic        last;
} path_word_t;

class path_scoreboard;
  bit          adj [16][16];
  logic [7:0]  wgt [16][16];
  logic [7:0]  heur [16];
  logic [7:0]  dflt_weight;
  path_word_t  pending_words [$];
  int          n_err;

  function void clear_graph();
    foreach (adj[i, j]) begin
      adj[i][j] = 0;
      wgt[i][j] = 0;
    end
    foreach (heur[i]) heur[i] = 0;
    dflt_weight = 8'd1;
    pending_words.delete();
    n_err = 0;
  endfunction

  function int unsigned est(int unsigned n, int unsigned goal);
    int unsigned h;
    if (n == goal) return 0;
    h = heur[n];
    if (h == 0) h = (n > goal) ? n - goal : goal - n;
    return h;
  endfunction

  function int unsigned link_len(int unsigned a, int unsigned b);
    if (a == b) return 0;
    return (wgt[a][b] != 0) ? wgt[a][b] : dflt_weight;
  endfunction

  function void push_word(bit f, int unsigned n, int unsigned c, bit l);
    path_word_t w;
    w.found = f;
    w.node = n[3:0];
    w.cost = c[15:0];
    w.last = l;
    pending_words = {pending_words, w};
  endfunction

  // A* run; appends expected path words
  function void run_search(int unsigned start, int unsigned goal);
    int unsigned sc [16];
    int unsigned parent [16];
    bit          has_par [16];
    bit          done [16];
    int unsigned best, act, g, ha, t, n, cost;
    bit          l;
    for (int i = 0; i < 16; i++) begin
      sc[i] = 65535;
      parent[i] = 0;
      has_par[i] = 0;
      done[i] = 0;
    end
    sc[start] = est(start, goal);
    for (int it = 0; it < 16; it++) begin
      best = 65535;
      act = 16;
      for (int i = 0; i < 16; i++)
        if (!done[i] && sc[i] < best) begin
          best = sc[i];
          act = i;
        end
      if (act >= 16) break;
      done[act] = 1;
      if (act == goal) begin
        n = goal;
        cost = 0;
        for (int s = 0; s < 16 && has_par[n]; s++) begin
          cost += link_len(n, parent[n]);
          if (cost > 65534) cost = 65534;
          n = parent[n];
        end
        n = goal;
        for (int k = 0; k < 16; k++) begin
          l = !has_par[n] || k == 15;
          push_word(1'b1, n, cost, l);
          if (l) return;
          n = parent[n];
        end
        return;
      end
      ha = est(act, goal);
      g = (sc[act] >= ha) ? sc[act] - ha : 0;
      for (int c = 0; c < 16; c++) begin
        if (!adj[act][c]) continue;
        t = g + link_len(act, c) + est(c, goal);
        if (t > 65534) t = 65534;
        if (t < sc[c]) begin
          sc[c] = t;
          parent[c] = act;
          has_par[c] = 1;
        end
      end
    end
    push_word(1'b0, 0, 0, 1'b1);
  endfunction

  // note an accepted input word
  function void note_input(logic [1:0] f, logic [3:0] a, logic [3:0] b,
                           logic [7:0] w, logic [7:0] h);
    case (f)
      asps_pkg::FUNC_EDGE: begin
        adj[a][b] = 1;
        if (w != 0) begin
          wgt[a][b] = w;
          wgt[b][a] = w;
        end
      end
      asps_pkg::FUNC_HEUR: heur[a] = h;
      asps_pkg::FUNC_SEARCH: run_search(a, b);
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_err++;
  endtask

  // check one accepted path word
  task check_word(path_word_t got);
    path_word_t exp_w;
    if (pending_words.size() == 0) begin
      report($sformatf("unexpected word %p", got));
      return;
    end
    exp_w = pending_words.pop_front();
    if (got.found !== exp_w.found)
      report($sformatf("found %b, want %b", got.found, exp_w.found));
    if (got.node !== exp_w.node)
      report($sformatf("path_node %0d, want %0d", got.node, exp_w.node));
    if (got.cost !== exp_w.cost)
      report($sformatf("path_cost %0d, want %0d", got.cost, exp_w.cost));
    if (got.last !== exp_w.last)
      report($sformatf("last %b, want %b", got.last, exp_w.last));
  endtask
endclass

module astar_path_search_top_tb;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [3:0]  first_node = '0;
  logic [3:0]  second_node = '0;
  logic [7:0]  edge_weight = '0;
  logic [7:0]  heuristic_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [3:0]  path_node;
  logic [15:0] path_cost;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  path_scoreboard sb;
  bit quiet_phase = 0;
  bit sink_stalls = 1;
  int cycle_cnt = 0;

  always #4 clk = ~clk;

  astar_path_search_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .first_node(first_node), .second_node(second_node),
    .edge_weight(edge_weight), .heuristic_value(heuristic_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .path_node(path_node), .path_cost(path_cost), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // timeout guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: sample at rising edge, check accepted words
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word({found, path_node, path_cost, last});
  end

  // result side ready, random stall bursts
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      if (sink_stalls && !quiet_phase) begin
        gap = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // drive one input word and wait for acceptance
  task automatic send_word(logic [1:0] f, logic [3:0] a, logic [3:0] b,
                           logic [7:0] w, logic [7:0] h);
    func <= f;
    first_node <= a;
    second_node <= b;
    edge_weight <= w;
    heuristic_value <= h;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, a, b, w, h);
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every expected word arrived, then let the search settle
  task automatic drain();
    int guard;
    idle_input();
    guard = 0;
    while (sb.pending_words.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_default(logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.dflt_weight = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_edge();
    send_word(asps_pkg::FUNC_EDGE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
              8'($urandom));
  endtask

  // a graph phase: edges, heuristics, then searches
  task automatic rand_phase(int n_edges, int n_search);
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(0, 4) == 0)
        send_word(asps_pkg::FUNC_HEUR, 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)),
                  8'($urandom), ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom));
      else if ($urandom_range(0, 19) == 0)
        send_word(asps_pkg::FUNC_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom),
                  8'($urandom));
      else
        rand_edge();
    end
    for (int i = 0; i < n_search; i++)
      send_word(asps_pkg::FUNC_SEARCH, 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear_graph();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty graph, start equals goal, chain, extremes
    send_word(asps_pkg::FUNC_SEARCH, 4'd0, 4'd15, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_SEARCH, 4'd15, 4'd15, 8'hFF, 8'hFF);
    send_word(asps_pkg::FUNC_EDGE, 4'd0, 4'd1, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_EDGE, 4'd1, 4'd2, 8'd255, 8'd255);
    send_word(asps_pkg::FUNC_EDGE, 4'd2, 4'd15, 8'd1, 8'd0);
    send_word(asps_pkg::FUNC_EDGE, 4'd0, 4'd15, 8'd200, 8'd0);
    send_word(asps_pkg::FUNC_EDGE, 4'd5, 4'd5, 8'd7, 8'd0);
    send_word(asps_pkg::FUNC_HEUR, 4'd1, 4'd0, 8'd0, 8'd255);
    send_word(asps_pkg::FUNC_HEUR, 4'd2, 4'd0, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_UNUSED, 4'd15, 4'd15, 8'hFF, 8'hFF);
    send_word(asps_pkg::FUNC_SEARCH, 4'd0, 4'd15, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_SEARCH, 4'd15, 4'd0, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_SEARCH, 4'd5, 4'd5, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_EDGE, 4'd15, 4'd0, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_SEARCH, 4'd15, 4'd0, 8'd0, 8'd0);
    drain();
    write_default(8'd255);
    send_word(asps_pkg::FUNC_SEARCH, 4'd0, 4'd15, 8'd0, 8'd0);
    send_word(asps_pkg::FUNC_SEARCH, 4'd15, 4'd0, 8'd0, 8'd0);
    drain();
    write_default(8'd1);

    // random phases across register settings
    rand_phase(30, 6);
    drain();
    write_default(8'($urandom_range(2, 254)));
    rand_phase(25, 6);
    drain();
    write_default(8'd255);
    rand_phase(20, 5);
    drain();
    write_default(8'd0);
    rand_phase(10, 5);
    drain();
    write_default(8'd1);
    quiet_phase = 1;
    sink_stalls = 0;
    rand_phase(8, 6);
    drain();

    if (sb.n_err == 0 && sb.pending_words.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
